@@ rtl/core/clts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the transfer-step decoder for the LCD transfer sequencer.
package clts_pkg;

  // Request codes on in_cmd.
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_BYTE   = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_CURSOR = 3'd3;
  localparam logic [2:0] CMD_GLYPH  = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;
  localparam logic [2:0] CMD_HOME   = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FOUR_BIT     = 2'd0;
  localparam logic [1:0] CFG_LINE_COUNT   = 2'd1;
  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd2;
  localparam logic [1:0] CFG_TALL_FONT    = 2'd3;

  // Job kinds held in the queue.
  localparam logic [1:0] KIND_INIT   = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_GLYPH  = 2'd2;

  // Bus constants.
  localparam logic [7:0] LCD_CLEAR      = 8'h01;
  localparam logic [7:0] LCD_HOME       = 8'h02;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
  localparam logic [7:0] LCD_CGRAM      = 8'h40;
  localparam logic [7:0] LCD_DDRAM      = 8'h80;
  localparam logic [7:0] LCD_FUNC_SET   = 8'h20;
  localparam logic [7:0] LCD_FS_8BIT    = 8'h10;
  localparam logic [7:0] LCD_FS_2LINE   = 8'h08;
  localparam logic [7:0] LCD_FS_TALL    = 8'h04;
  localparam logic [7:0] LCD_ROW1_OFS   = 8'h40;
  localparam logic [7:0] NIB_WAKE       = 8'h03;
  localparam logic [7:0] NIB_4BIT       = 8'h02;

  // Waits in microseconds.
  localparam logic [15:0] WAIT_POWER_UP = 16'd50000;
  localparam logic [15:0] WAIT_WAKE1    = 16'd4500;
  localparam logic [15:0] WAIT_WAKE3    = 16'd150;
  localparam logic [15:0] WAIT_CLEAR    = 16'd2000;

  // Last step index of the longest job (init in four-bit mode, glyph).
  localparam logic [3:0] STEP_MAX = 4'd8;

  // Queue depth between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic       four_bit;
    logic [2:0] line_count;
    logic [6:0] column_count;
    logic       tall_font;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        rs;
    logic        long_wait;
    logic [7:0]  byte0;
    logic [63:0] glyph;
  } entry_t;

  // One step of a job: a byte (split in four-bit mode), a raw nibble, or a wait.
  typedef struct packed {
    logic        strobe;
    logic        is_byte;
    logic        rs;
    logic [7:0]  data;
    logic [15:0] wait_us;
    logic        last;
  } op_t;

  // Decodes step j of a queued job under the current configuration.
  function automatic op_t op_desc(entry_t e, logic [3:0] j, cfg_t cfg);
    op_t        op;
    logic [7:0] fs;
    logic [2:0] gi;
    fs = LCD_FUNC_SET;
    if (!cfg.four_bit) fs = fs | LCD_FS_8BIT;
    if (cfg.line_count > 3'd1) fs = fs | LCD_FS_2LINE;
    if (cfg.tall_font && cfg.line_count == 3'd1) fs = fs | LCD_FS_TALL;
    gi = 3'(j - 4'd1);
    op.strobe  = 1'b1;
    op.is_byte = 1'b1;
    op.rs      = 1'b0;
    op.data    = 8'h00;
    op.wait_us = 16'd0;
    op.last    = 1'b0;
    unique case (e.kind)
      KIND_INIT: begin
        if (j == 4'd0) begin
          op.strobe  = 1'b0;
          op.is_byte = 1'b0;
          op.wait_us = WAIT_POWER_UP;
        end else if (cfg.four_bit) begin
          case (j) inside
            4'd1, 4'd2: begin
              op.is_byte = 1'b0;
              op.data    = NIB_WAKE;
              op.wait_us = WAIT_WAKE1;
            end
            4'd3: begin
              op.is_byte = 1'b0;
              op.data    = NIB_WAKE;
              op.wait_us = WAIT_WAKE3;
            end
            4'd4: begin
              op.is_byte = 1'b0;
              op.data    = NIB_4BIT;
            end
            4'd5: op.data = fs;
            4'd6: op.data = LCD_DISP_ON;
            4'd7: begin
              op.data    = LCD_CLEAR;
              op.wait_us = WAIT_CLEAR;
            end
            default: begin
              op.data = LCD_ENTRY_MODE;
              op.last = 1'b1;
            end
          endcase
        end else begin
          case (j) inside
            4'd1: begin
              op.data    = fs;
              op.wait_us = WAIT_WAKE1;
            end
            4'd2: begin
              op.data    = fs;
              op.wait_us = WAIT_WAKE3;
            end
            4'd3, 4'd4: op.data = fs;
            4'd5: op.data = LCD_DISP_ON;
            4'd6: begin
              op.data    = LCD_CLEAR;
              op.wait_us = WAIT_CLEAR;
            end
            default: begin
              op.data = LCD_ENTRY_MODE;
              op.last = 1'b1;
            end
          endcase
        end
      end
      KIND_SINGLE: begin
        op.rs      = e.rs;
        op.data    = e.byte0;
        op.wait_us = e.long_wait ? WAIT_CLEAR : 16'd0;
        op.last    = 1'b1;
      end
      KIND_GLYPH: begin
        if (j == 4'd0) begin
          op.data = e.byte0;
        end else begin
          op.rs   = 1'b1;
          op.data = e.glyph[{gi, 3'b000} +: 8];
          op.last = (j == STEP_MAX);
        end
      end
      default: begin
        op.strobe  = 1'b0;
        op.is_byte = 1'b0;
        op.last    = 1'b1;
      end
    endcase
    return op;
  endfunction

endpackage

@@ rtl/core/clts_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts requests and turns them into queued jobs.
module clts_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_cmd,
  input  logic [7:0]            in_value,
  input  logic [7:0]            in_column,
  input  logic [7:0]            in_row,
  input  logic [2:0]            in_slot,
  input  logic [63:0]           in_glyph_rows,
  input  clts_pkg::cfg_t        cfg,
  input  logic                  q_full,
  output logic                  q_push,
  output clts_pkg::entry_t      q_entry
);

  logic [1:0] row_clamp;
  logic [7:0] row_ofs;
  logic [7:0] addr;

  // Clamp the row to three, then to the last display line.
  always_comb begin
    row_clamp = (in_row > 8'd3) ? 2'd3 : in_row[1:0];
    if (cfg.line_count == 3'd0) begin
      row_clamp = 2'd0;
    end else if ({1'b0, row_clamp} >= cfg.line_count) begin
      row_clamp = 2'(cfg.line_count - 3'd1);
    end
    case (row_clamp)
      2'd0:    row_ofs = 8'h00;
      2'd1:    row_ofs = clts_pkg::LCD_ROW1_OFS;
      2'd2:    row_ofs = {1'b0, cfg.column_count};
      default: row_ofs = clts_pkg::LCD_ROW1_OFS + {1'b0, cfg.column_count};
    endcase
    addr = in_column + row_ofs;
  end

  // Classify the request into a job.
  always_comb begin
    q_entry.kind      = clts_pkg::KIND_SINGLE;
    q_entry.rs        = 1'b0;
    q_entry.long_wait = 1'b0;
    q_entry.byte0     = in_value;
    q_entry.glyph     = in_glyph_rows;
    unique case (in_cmd)
      clts_pkg::CMD_INIT:   q_entry.kind = clts_pkg::KIND_INIT;
      clts_pkg::CMD_BYTE:   q_entry.byte0 = in_value;
      clts_pkg::CMD_DATA:   q_entry.rs = 1'b1;
      clts_pkg::CMD_CURSOR: q_entry.byte0 = clts_pkg::LCD_DDRAM | addr;
      clts_pkg::CMD_GLYPH: begin
        q_entry.kind  = clts_pkg::KIND_GLYPH;
        q_entry.byte0 = clts_pkg::LCD_CGRAM | {2'b00, in_slot, 3'b000};
      end
      clts_pkg::CMD_CLEAR: begin
        q_entry.byte0     = clts_pkg::LCD_CLEAR;
        q_entry.long_wait = 1'b1;
      end
      clts_pkg::CMD_HOME: begin
        q_entry.byte0     = clts_pkg::LCD_HOME;
        q_entry.long_wait = 1'b1;
      end
      default: q_entry.kind = clts_pkg::KIND_SINGLE;
    endcase
  end

  // The unused code is taken and dropped.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && (in_cmd <= clts_pkg::CMD_HOME);

endmodule

@@ rtl/core/clts_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between the front end and the transfer sequencer.
module clts_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  clts_pkg::entry_t      push_entry,
  input  logic                  pop,
  output clts_pkg::entry_t      head,
  output logic                  full,
  output logic                  empty
);

  clts_pkg::entry_t                  mem_r [clts_pkg::Q_DEPTH];
  logic [clts_pkg::Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [clts_pkg::Q_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [clts_pkg::Q_CNT_W-1:0]      count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == clts_pkg::Q_DEPTH - 1) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == clts_pkg::Q_DEPTH - 1) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  assign head  = mem_r[rd_ptr_r];
  assign full  = (32'(count_r) == clts_pkg::Q_DEPTH);
  assign empty = (count_r == '0);

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> 32'(count_r) != clts_pkg::Q_DEPTH) else $error("queue pushed while full");
`endif

endmodule

@@ rtl/core/clts_back.sv @@
`timescale 1ns / 1ps
// Back end: walks each queued job and drives one bus transfer per cycle while out_ready allows.
module clts_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  clts_pkg::cfg_t        cfg,
  input  clts_pkg::entry_t      q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_strobe_res,
  output logic                  out_reg_select,
  output logic [7:0]            out_bus_data,
  output logic [15:0]           out_wait_after_us,
  output logic                  out_last
);

  logic [3:0]       step_r, step_nxt;
  logic             half_r, half_nxt;
  logic             valid_r, valid_nxt;
  logic             strobe_r, strobe_nxt;
  logic             rs_r, rs_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [15:0]      wait_r, wait_nxt;
  logic             last_r, last_nxt;
  logic             adv;
  logic             split;
  clts_pkg::op_t    op;

  assign op    = clts_pkg::op_desc(q_head, step_r, cfg);
  assign split = op.is_byte && cfg.four_bit;
  assign adv   = !valid_r || out_ready;

  // Step sequencing and output register load.
  always_comb begin
    step_nxt   = step_r;
    half_nxt   = half_r;
    valid_nxt  = valid_r;
    strobe_nxt = strobe_r;
    rs_nxt     = rs_r;
    data_nxt   = data_r;
    wait_nxt   = wait_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    if (adv) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        strobe_nxt = op.strobe;
        rs_nxt     = op.rs;
        if (split && !half_r) begin
          // High nibble goes first with no extra wait.
          data_nxt = {4'h0, op.data[7:4]};
          wait_nxt = 16'd0;
          last_nxt = 1'b0;
          half_nxt = 1'b1;
        end else begin
          data_nxt = split ? {4'h0, op.data[3:0]} : op.data;
          wait_nxt = op.wait_us;
          last_nxt = op.last;
          half_nxt = 1'b0;
          if (op.last) begin
            step_nxt = 4'd0;
            q_pop    = 1'b1;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 4'd0;
      half_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      half_r  <= half_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    strobe_r <= strobe_nxt;
    rs_r     <= rs_nxt;
    data_r   <= data_nxt;
    wait_r   <= wait_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid         = valid_r;
  assign out_strobe_res    = strobe_r;
  assign out_reg_select    = rs_r;
  assign out_bus_data      = data_r;
  assign out_wait_after_us = wait_r;
  assign out_last          = last_r;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= clts_pkg::STEP_MAX) else $error("step index out of range");
  a_mid_job_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != 4'd0 || half_r) |-> !q_empty) else $error("job left the queue early");
  a_half_four_bit: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> cfg.four_bit) else $error("nibble split in eight-bit mode");
`endif

endmodule

@@ rtl/core/char_lcd_transfer_sequencer_top.sv @@
`timescale 1ns / 1ps
// Top level of the character LCD transfer sequencer.
//
// Each request on the in_ channel (init, command byte, data byte, cursor,
// glyph load, clear, home) becomes a run of bus transfers on the out_
// channel, the final one flagged by out_last. A transfer is either an enable
// strobe with RS and a byte (or a nibble in four-bit mode, high nibble first)
// or a wait only; out_wait_after_us is the extra wait to hold after it.
// A request is held in the queue before its first transfer is loaded into the
// output register; transfers then follow one per cycle while out_ready is high,
// and a request makes 1 to 18 transfers (a four-bit glyph load is the longest).
// The output register is loaded by a step counter that walks the job at the
// head of a two-entry queue; the next request is taken while one is being
// sent, and the last transfer of one job is followed directly by the first
// of the next. Unused command code seven is taken and dropped.
// When out_ready is low the output register holds and the queue fills; in_ready
// drops once the queue is full. Configuration writes take effect at once; the
// user must make them while no request is in flight; the block does not enforce
// it. Synchronous reset empties the queue, clears the output and loads the
// register defaults (four-bit, one line, sixteen columns, normal font).
module char_lcd_transfer_sequencer_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [2:0]   in_cmd,
  input  logic [7:0]   in_value,
  input  logic [7:0]   in_column,
  input  logic [7:0]   in_row,
  input  logic [2:0]   in_slot,
  input  logic [63:0]  in_glyph_rows,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_strobe_res,
  output logic         out_reg_select,
  output logic [7:0]   out_bus_data,
  output logic [15:0]  out_wait_after_us,
  output logic         out_last,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  clts_pkg::cfg_t    cfg_r, cfg_nxt;
  clts_pkg::entry_t  push_entry;
  clts_pkg::entry_t  head;
  logic              q_push, q_pop, q_full, q_empty;

  // Configuration registers.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        clts_pkg::CFG_FOUR_BIT:     cfg_nxt.four_bit     = cfg_data[0];
        clts_pkg::CFG_LINE_COUNT:   cfg_nxt.line_count   = cfg_data[2:0];
        clts_pkg::CFG_COLUMN_COUNT: cfg_nxt.column_count = cfg_data;
        clts_pkg::CFG_TALL_FONT:    cfg_nxt.tall_font    = cfg_data[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.four_bit     <= 1'b1;
      cfg_r.line_count   <= 3'd1;
      cfg_r.column_count <= 7'd16;
      cfg_r.tall_font    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  clts_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_slot       (in_slot),
    .in_glyph_rows (in_glyph_rows),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  clts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  clts_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_head            (head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_strobe_res    (out_strobe_res),
    .out_reg_select    (out_reg_select),
    .out_bus_data      (out_bus_data),
    .out_wait_after_us (out_wait_after_us),
    .out_last          (out_last)
  );

endmodule

@@ dv/tb_char_lcd_transfer_sequencer_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the character LCD transfer sequencer top level.
module tb_char_lcd_transfer_sequencer_top;

  // Code seven is outside the request set and must be dropped silently.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  // Margin of idle cycles before the registers are rewritten.
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 130;

  typedef struct packed {
    logic        strobe;
    logic        rs;
    logic [7:0]  data;
    logic [15:0] wait_us;
    logic        last;
  } xfer_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  value;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [2:0]  slot;
    logic [63:0] glyph;
  } lcd_req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_cmd;
  logic [7:0]  in_value;
  logic [7:0]  in_column;
  logic [7:0]  in_row;
  logic [2:0]  in_slot;
  logic [63:0] in_glyph_rows;
  logic        out_valid;
  logic        out_ready;
  logic        out_strobe_res;
  logic        out_reg_select;
  logic [7:0]  out_bus_data;
  logic [15:0] out_wait_after_us;
  logic        out_last;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  // Local copy of the configuration registers.
  logic       bus4;
  logic [2:0] lines;
  logic [6:0] cols;
  logic       tall;

  xfer_t pending_xfers[$];
  xfer_t run_xfers[$];
  int    errors = 0;
  int    quiet_cycles = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;

  char_lcd_transfer_sequencer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_value(in_value),
    .in_column(in_column),
    .in_row(in_row),
    .in_slot(in_slot),
    .in_glyph_rows(in_glyph_rows),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_strobe_res(out_strobe_res),
    .out_reg_select(out_reg_select),
    .out_bus_data(out_bus_data),
    .out_wait_after_us(out_wait_after_us),
    .out_last(out_last),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Appends one bus transfer to the run being built.
  function automatic void add_xfer(input logic strobe_bit, input logic rs,
                                   input logic [7:0] data, input logic [15:0] wait_us);
    xfer_t x;
    x.strobe  = strobe_bit;
    x.rs      = rs;
    x.data    = data;
    x.wait_us = wait_us;
    x.last    = 1'b0;
    run_xfers.push_back(x);
  endfunction

  // A byte is one strobe on the eight-bit bus, or two nibbles high first.
  function automatic void add_byte(input logic rs, input logic [7:0] b,
                                   input logic [15:0] wait_us);
    if (bus4) begin
      add_xfer(1'b1, rs, {4'h0, b[7:4]}, 16'd0);
      add_xfer(1'b1, rs, {4'h0, b[3:0]}, wait_us);
    end else begin
      add_xfer(1'b1, rs, b, wait_us);
    end
  endfunction

  // Works out the transfers one request produces and queues them.
  function automatic void expand_request(input lcd_req_t r);
    xfer_t      x;
    logic [7:0] fs;
    logic [7:0] rr;
    logic [7:0] ofs;
    logic [7:0] pos;
    run_xfers.delete();
    fs = clts_pkg::LCD_FUNC_SET;
    if (!bus4) fs = fs | clts_pkg::LCD_FS_8BIT;
    if (lines > 3'd1) fs = fs | clts_pkg::LCD_FS_2LINE;
    if (tall && lines == 3'd1) fs = fs | clts_pkg::LCD_FS_TALL;
    case (r.cmd)
      clts_pkg::CMD_INIT: begin
        add_xfer(1'b0, 1'b0, 8'h00, clts_pkg::WAIT_POWER_UP);
        if (bus4) begin
          add_xfer(1'b1, 1'b0, clts_pkg::NIB_WAKE, clts_pkg::WAIT_WAKE1);
          add_xfer(1'b1, 1'b0, clts_pkg::NIB_WAKE, clts_pkg::WAIT_WAKE1);
          add_xfer(1'b1, 1'b0, clts_pkg::NIB_WAKE, clts_pkg::WAIT_WAKE3);
          add_xfer(1'b1, 1'b0, clts_pkg::NIB_4BIT, 16'd0);
        end else begin
          add_byte(1'b0, fs, clts_pkg::WAIT_WAKE1);
          add_byte(1'b0, fs, clts_pkg::WAIT_WAKE3);
          add_byte(1'b0, fs, 16'd0);
        end
        add_byte(1'b0, fs, 16'd0);
        add_byte(1'b0, clts_pkg::LCD_DISP_ON, 16'd0);
        add_byte(1'b0, clts_pkg::LCD_CLEAR, clts_pkg::WAIT_CLEAR);
        add_byte(1'b0, clts_pkg::LCD_ENTRY_MODE, 16'd0);
      end
      clts_pkg::CMD_BYTE: add_byte(1'b0, r.value, 16'd0);
      clts_pkg::CMD_DATA: add_byte(1'b1, r.value, 16'd0);
      clts_pkg::CMD_CURSOR: begin
        // Clamp the row to four lines, then to the configured line count.
        rr = r.row;
        if (rr > 8'd3) rr = 8'd3;
        if (lines == 3'd0) rr = 8'd0;
        else if (rr >= {5'd0, lines}) rr = {5'd0, lines} - 8'd1;
        case (rr[1:0])
          2'd0: ofs = 8'h00;
          2'd1: ofs = clts_pkg::LCD_ROW1_OFS;
          2'd2: ofs = {1'b0, cols};
          default: ofs = clts_pkg::LCD_ROW1_OFS + {1'b0, cols};
        endcase
        pos = r.column + ofs;
        add_byte(1'b0, clts_pkg::LCD_DDRAM | pos, 16'd0);
      end
      clts_pkg::CMD_GLYPH: begin
        add_byte(1'b0, clts_pkg::LCD_CGRAM | {2'b00, r.slot, 3'b000}, 16'd0);
        for (int i = 0; i < 8; i++) add_byte(1'b1, r.glyph[8*i +: 8], 16'd0);
      end
      clts_pkg::CMD_CLEAR: add_byte(1'b0, clts_pkg::LCD_CLEAR, clts_pkg::WAIT_CLEAR);
      clts_pkg::CMD_HOME: add_byte(1'b0, clts_pkg::LCD_HOME, clts_pkg::WAIT_CLEAR);
      default: ;
    endcase
    if (run_xfers.size() > 0) begin
      x = run_xfers[run_xfers.size() - 1];
      x.last = 1'b1;
      run_xfers[run_xfers.size() - 1] = x;
    end
    foreach (run_xfers[i]) pending_xfers.push_back(run_xfers[i]);
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  function automatic lcd_req_t make_req(input logic [2:0] cmd, input logic [7:0] value,
                                        input logic [7:0] column, input logic [7:0] row,
                                        input logic [2:0] slot, input logic [63:0] glyph);
    lcd_req_t r;
    r.cmd    = cmd;
    r.value  = value;
    r.column = column;
    r.row    = row;
    r.slot   = slot;
    r.glyph  = glyph;
    return r;
  endfunction

  function automatic lcd_req_t random_request();
    lcd_req_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 5) r.cmd = clts_pkg::CMD_INIT;
    else if (pick < 10) r.cmd = CMD_UNUSED;
    else r.cmd = 3'($urandom_range(1, 6));
    r.value  = 8'($urandom);
    r.column = 8'($urandom);
    // Half the cursor rows sit near the clamp boundary.
    r.row    = ($urandom_range(1) == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
    r.slot   = 3'($urandom);
    r.glyph  = {$urandom, $urandom};
    return r;
  endfunction

  // Idles cycle by cycle with the phase's odds, then offers one request
  // and waits until it is taken.
  task automatic send_req(input lcd_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= r.cmd;
    in_value      <= r.value;
    in_column     <= r.column;
    in_row        <= r.row;
    in_slot       <= r.slot;
    in_glyph_rows <= r.glyph;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expand_request(r);
  endtask

  // Stops sending and waits until the block has nothing left in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_xfers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [6:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles; only called while idle.
  task automatic set_config(input logic fb, input logic [2:0] lc, input logic [6:0] cc,
                            input logic tf);
    put_reg(clts_pkg::CFG_FOUR_BIT, {6'd0, fb});
    put_reg(clts_pkg::CFG_LINE_COUNT, {4'd0, lc});
    put_reg(clts_pkg::CFG_COLUMN_COUNT, cc);
    put_reg(clts_pkg::CFG_TALL_FONT, {6'd0, tf});
    cfg_wr_en <= 1'b0;
    bus4  = fb;
    lines = lc;
    cols  = cc;
    tall  = tf;
  endtask

  task automatic reconfigure_random();
    logic [2:0] lc;
    logic [6:0] cc;
    if ($urandom_range(3) == 0) lc = 3'($urandom_range(0, 7));
    else lc = 3'($urandom_range(1, 4));
    case ($urandom_range(3))
      0: cc = 7'd0;
      1: cc = 7'd127;
      default: cc = 7'($urandom);
    endcase
    set_config(1'($urandom), lc, cc, 1'($urandom));
  endtask

  // Every request kind under the register defaults, no writes yet.
  task automatic test_reset_defaults();
    send_req(make_req(clts_pkg::CMD_INIT, 8'h00, 8'h00, 8'h00, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_BYTE, 8'h00, 8'h00, 8'h00, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_DATA, 8'hFF, 8'h00, 8'h00, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_CURSOR, 8'h00, 8'hFF, 8'hFF, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_GLYPH, 8'h00, 8'h00, 8'h00, 3'd7, '1));
    send_req(make_req(clts_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_HOME, 8'h00, 8'h00, 8'h00, 3'd0, 64'd0));
    send_req(make_req(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 3'd7, '1));
  endtask

  // Eight-bit bus with two lines; the tall font must not be honored here.
  task automatic test_eight_bit_bus();
    settle();
    set_config(1'b0, 3'd2, 7'd64, 1'b1);
    send_req(make_req(clts_pkg::CMD_INIT, 8'h00, 8'h00, 8'h00, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_BYTE, 8'hA5, 8'h00, 8'h00, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_DATA, 8'h00, 8'h00, 8'h00, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_GLYPH, 8'h00, 8'h00, 8'h00, 3'd0,
                      64'h0123_4567_89AB_CDEF));
    send_req(make_req(clts_pkg::CMD_CURSOR, 8'h00, 8'h3F, 8'd1, 3'd0, 64'd0));
  endtask

  // Row clamping at zero lines, above four lines, and the column offsets.
  task automatic test_row_clamp();
    settle();
    set_config(1'b1, 3'd0, 7'd127, 1'b1);
    send_req(make_req(clts_pkg::CMD_INIT, 8'h00, 8'h00, 8'h00, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_CURSOR, 8'h00, 8'h10, 8'd3, 3'd0, 64'd0));
    settle();
    set_config(1'b0, 3'd7, 7'd127, 1'b0);
    send_req(make_req(clts_pkg::CMD_CURSOR, 8'h00, 8'hC0, 8'd2, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_CURSOR, 8'h00, 8'hFF, 8'hFF, 3'd0, 64'd0));
    settle();
    set_config(1'b1, 3'd4, 7'd0, 1'b1);
    send_req(make_req(clts_pkg::CMD_CURSOR, 8'h00, 8'h01, 8'd3, 3'd0, 64'd0));
    send_req(make_req(clts_pkg::CMD_CURSOR, 8'h00, 8'h55, 8'd2, 3'd0, 64'd0));
    settle();
    set_config(1'b0, 3'd1, 7'd16, 1'b1);
    send_req(make_req(clts_pkg::CMD_INIT, 8'h00, 8'h00, 8'h00, 3'd0, 64'd0));
  endtask

  // Random requests in three idling phases, reconfigured now and then.
  task automatic test_random_traffic();
    lcd_req_t r;
    int       sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sent % 45 == 0) begin
          settle();
          reconfigure_random();
        end
        r = random_request();
        send_req(r);
        if (r.cmd != CMD_UNUSED) sent++;
      end
    end
  endtask

  // Result side: random back-pressure, watchdog and in-order comparison.
  always @(posedge clk) begin
    xfer_t got;
    xfer_t want;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      got.strobe  = out_strobe_res;
      got.rs      = out_reg_select;
      got.data    = out_bus_data;
      got.wait_us = out_wait_after_us;
      got.last    = out_last;
      if (pending_xfers.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, got %p", $time, got);
      end else begin
        want = pending_xfers.pop_front();
        compare_field("strobe_res", 16'(want.strobe), 16'(got.strobe));
        compare_field("reg_select", 16'(want.rs), 16'(got.rs));
        compare_field("bus_data", 16'(want.data), 16'(got.data));
        compare_field("wait_after_us", want.wait_us, got.wait_us);
        compare_field("last", 16'(want.last), 16'(got.last));
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= clts_pkg::CMD_INIT;
    in_value      <= 8'h00;
    in_column     <= 8'h00;
    in_row        <= 8'h00;
    in_slot       <= 3'd0;
    in_glyph_rows <= 64'd0;
    out_ready     <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= clts_pkg::CFG_FOUR_BIT;
    cfg_data      <= 7'd0;
    // Register defaults after reset.
    bus4  = 1'b1;
    lines = 3'd1;
    cols  = 7'd16;
    tall  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_eight_bit_bus();
    test_row_clamp();
    test_random_traffic();
    settle();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
